[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked in the same cycle, skipped while reset is high
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// implication checked in the next cycle, with an explicit disable condition
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

[rtl/ctl_pkg.sv]
`timescale 1ns / 1ps
package ctl_pkg;

   localparam logic [3:0] MODE_IDLE   = 4'd0;
   localparam logic [3:0] MODE_NAME   = 4'd1;
   localparam logic [3:0] MODE_ZERO   = 4'd2;
   localparam logic [3:0] MODE_DEC    = 4'd3;
   localparam logic [3:0] MODE_HEX    = 4'd4;
   localparam logic [3:0] MODE_STR_DQ = 4'd5;
   localparam logic [3:0] MODE_STR_SQ = 4'd6;
   localparam logic [3:0] MODE_OP1    = 4'd7;
   localparam logic [3:0] MODE_OPSH   = 4'd8;
   localparam logic [3:0] MODE_OPDONE = 4'd9;

   localparam logic [1:0] KIND_NAME = 2'd0;
   localparam logic [1:0] KIND_NUM  = 2'd1;
   localparam logic [1:0] KIND_STR  = 2'd2;
   localparam logic [1:0] KIND_OP   = 2'd3;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_DQ    = 8'h22;
   localparam logic [7:0] CH_SQ    = 8'h27;
   localparam logic [7:0] CH_UNDER = 8'h5F;
   localparam logic [7:0] CH_DOLL  = 8'h24;
   localparam logic [7:0] CH_TILDE = 8'h7E;
   localparam logic [7:0] CH_LX    = 8'h78;
   localparam logic [7:0] CH_UX    = 8'h58;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_PCT   = 8'h25;
   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_BAR   = 8'h7C;
   localparam logic [7:0] CH_CARET = 8'h5E;

   typedef struct packed {
      logic [3:0] mode;
      logic [7:0] hchar;
      logic       hvalid;
      logic       hfirst;
      logic [1:0] hkind;
   } lex_state_type;

   typedef struct packed {
      logic [7:0] ch;
      logic [1:0] kind;
      logic       first;
      logic       last;
      logic       empty;
   } token_type;

   localparam lex_state_type STATE_RESET = '{
      mode: MODE_IDLE, hchar: 8'h00, hvalid: 1'b0, hfirst: 1'b0, hkind: KIND_NAME};

   function automatic logic is_digit(input logic [7:0] c);
      return c inside {[8'h30:8'h39]};
   endfunction

   function automatic logic is_name_init(input logic [7:0] c);
      return c inside {[8'h41:8'h5A], [8'h61:8'h7A], CH_UNDER, CH_DOLL};
   endfunction

   function automatic logic is_name_char(input logic [7:0] c);
      return is_name_init(c) || is_digit(c);
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
   endfunction

   function automatic logic two_char_op(input logic [7:0] c0, input logic [7:0] c1);
      logic r;
      r = 1'b0;
      if (c1 == CH_EQ && (c0 inside {CH_LT, CH_GT, CH_EQ, CH_BANG, CH_PLUS, CH_MINUS,
                                     CH_STAR, CH_PCT, CH_AMP, CH_BAR, CH_CARET}))
         r = 1'b1;
      if (c0 == CH_MINUS && (c1 == CH_MINUS || c1 == CH_GT))
         r = 1'b1;
      if ((c0 == CH_PLUS || c0 == CH_AMP || c0 == CH_BAR) && c1 == c0)
         r = 1'b1;
      return r;
   endfunction

   // load a fresh token character into the hold register
   function automatic lex_state_type hold(input logic [7:0] c, input logic [1:0] kind,
                                          input logic [3:0] mode);
      lex_state_type s;
      s.mode   = mode;
      s.hchar  = c;
      s.hvalid = 1'b1;
      s.hfirst = 1'b1;
      s.hkind  = kind;
      return s;
   endfunction

   // state after c opens a new token, or is skipped as white space
   function automatic lex_state_type start_token(input lex_state_type st,
                                                 input logic [7:0] c);
      lex_state_type s;
      s = st;
      s.hvalid = 1'b0;
      s.hfirst = 1'b0;
      if (c <= CH_SPACE || c[7]) begin
         s.mode = MODE_IDLE;
      end else if (is_name_init(c)) begin
         s = hold(c, KIND_NAME, MODE_NAME);
      end else if (is_digit(c)) begin
         s = hold(c, KIND_NUM, (c == 8'h30) ? MODE_ZERO : MODE_DEC);
      end else if (c == CH_DQ) begin
         s.mode  = MODE_STR_DQ;
         s.hkind = KIND_STR;
      end else if (c == CH_SQ) begin
         s.mode  = MODE_STR_SQ;
         s.hkind = KIND_STR;
      end else if (c <= CH_TILDE) begin
         s = hold(c, KIND_OP, MODE_OP1);
      end else begin
         s = hold(c, KIND_OP, MODE_OPDONE);
      end
      return s;
   endfunction

endpackage

[rtl/c_token_lexer.sv]
`timescale 1ns / 1ps
// c_token_lexer: splits one line of c-like text into token characters
// req channel: one line byte per word in req_tdata, a zero byte ends the line
// and flushes whatever token is open
// rsp channel: one token character per word; rsp_tlast closes a token,
// rsp_tuser carries kind, first mark and empty-string mark
// one input byte gives zero or one output word; the newest token character
// is held back until the next byte shows whether it closes its token
// a byte is registered in the input register on accept and stepped through the
// lexer once the output slot is free or leaving; the word it releases is
// registered in the output register, which drives rsp_tvalid
// throughput: one byte per cycle while rsp_tready is high, set by the combinational
// lexer step between the input register and the output register
// when rsp_tready is low the output word holds; one more byte can sit in the
// input register, then req_tready drops until the output drains
// reset clears both valid flags and returns the lexer to idle between tokens
module c_token_lexer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_char
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_char
   output logic       rsp_tlast,   // token_last
   output logic [3:0] rsp_tuser    // [1:0] token_kind, [2] token_first, [3] token_empty
);

   logic                   in_valid_ff, in_valid_in;
   logic [7:0]             in_char_ff, in_char_in;
   ctl_pkg::lex_state_type state_ff, state_in;
   logic                   out_valid_ff, out_valid_in;
   ctl_pkg::token_type     out_ff, out_in;
   ctl_pkg::lex_state_type step_state;
   ctl_pkg::token_type     step_result;
   logic                   step_emit;
   logic                   consume;
   logic                   req_take;

   ctl_step u_step (
      .cur_state (state_ff),
      .char_in   (in_char_ff),
      .nxt_state (step_state),
      .emit      (step_emit),
      .result    (step_result)
   );

   // the registered byte moves on whenever the output slot is free or leaving
   assign consume    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || consume;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in  = req_take ? 1'b1 : (consume ? 1'b0 : in_valid_ff);
      in_char_in   = req_take ? req_tdata : in_char_ff;
      state_in     = consume ? step_state : state_ff;
      out_valid_in = consume ? step_emit : (rsp_tready ? 1'b0 : out_valid_ff);
      out_in       = (consume && step_emit) ? step_result : out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= ctl_pkg::STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      in_char_ff <= in_char_in;
      out_ff     <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff.ch;
   assign rsp_tlast  = out_ff.last;
   assign rsp_tuser  = {out_ff.empty, out_ff.first, out_ff.kind};

endmodule

[rtl/ctl_step.sv]
`timescale 1ns / 1ps
module ctl_step (
   input  ctl_pkg::lex_state_type cur_state,
   input  logic [7:0]             char_in,
   output ctl_pkg::lex_state_type nxt_state,
   output logic                   emit,
   output ctl_pkg::token_type     result
);

   logic extend_en;
   logic finish_en;
   logic [3:0] ext_mode;

   // decide for this character whether the held one is emitted and how
   always_comb begin
      extend_en = 1'b0;
      finish_en = 1'b0;
      ext_mode  = cur_state.mode;
      nxt_state = cur_state;
      emit      = 1'b0;
      result    = '{ch: cur_state.hchar, kind: cur_state.hkind, first: cur_state.hfirst,
                    last: 1'b0, empty: 1'b0};

      if (char_in == ctl_pkg::CH_NUL) begin
         if (cur_state.hvalid) begin
            emit        = 1'b1;
            result.last = 1'b1;
         end else if (cur_state.mode == ctl_pkg::MODE_STR_DQ ||
                      cur_state.mode == ctl_pkg::MODE_STR_SQ) begin
            emit   = 1'b1;
            result = '{ch: 8'h00, kind: ctl_pkg::KIND_STR, first: 1'b1, last: 1'b1,
                       empty: 1'b1};
         end
         nxt_state = ctl_pkg::STATE_RESET;
      end else begin
         case (cur_state.mode)
            ctl_pkg::MODE_NAME: begin
               if (ctl_pkg::is_name_char(char_in)) begin
                  extend_en = 1'b1;
                  ext_mode  = ctl_pkg::MODE_NAME;
               end else begin
                  finish_en = 1'b1;
               end
            end
            ctl_pkg::MODE_ZERO: begin
               if (char_in == ctl_pkg::CH_LX || char_in == ctl_pkg::CH_UX) begin
                  extend_en = 1'b1;
                  ext_mode  = ctl_pkg::MODE_HEX;
               end else if (ctl_pkg::is_digit(char_in)) begin
                  extend_en = 1'b1;
                  ext_mode  = ctl_pkg::MODE_DEC;
               end else if (char_in == ctl_pkg::CH_UNDER) begin
                  nxt_state.mode = ctl_pkg::MODE_DEC;
               end else begin
                  finish_en = 1'b1;
               end
            end
            ctl_pkg::MODE_DEC: begin
               if (ctl_pkg::is_digit(char_in)) begin
                  extend_en = 1'b1;
                  ext_mode  = ctl_pkg::MODE_DEC;
               end else if (char_in != ctl_pkg::CH_UNDER) begin
                  finish_en = 1'b1;
               end
            end
            ctl_pkg::MODE_HEX: begin
               if (ctl_pkg::is_hex(char_in)) begin
                  extend_en = 1'b1;
                  ext_mode  = ctl_pkg::MODE_HEX;
               end else if (char_in != ctl_pkg::CH_UNDER) begin
                  finish_en = 1'b1;
               end
            end
            ctl_pkg::MODE_STR_DQ, ctl_pkg::MODE_STR_SQ: begin
               if ((cur_state.mode == ctl_pkg::MODE_STR_DQ && char_in == ctl_pkg::CH_DQ) ||
                   (cur_state.mode == ctl_pkg::MODE_STR_SQ && char_in == ctl_pkg::CH_SQ)) begin
                  emit = 1'b1;
                  if (cur_state.hvalid) begin
                     result = '{ch: cur_state.hchar, kind: ctl_pkg::KIND_STR,
                                first: cur_state.hfirst, last: 1'b1, empty: 1'b0};
                  end else begin
                     result = '{ch: 8'h00, kind: ctl_pkg::KIND_STR, first: 1'b1,
                                last: 1'b1, empty: 1'b1};
                  end
                  nxt_state = ctl_pkg::STATE_RESET;
               end else if (cur_state.hvalid) begin
                  extend_en = 1'b1;
                  ext_mode  = cur_state.mode;
               end else begin
                  nxt_state = ctl_pkg::hold(char_in, ctl_pkg::KIND_STR, cur_state.mode);
               end
            end
            ctl_pkg::MODE_OP1: begin
               if ((cur_state.hchar == ctl_pkg::CH_LT || cur_state.hchar == ctl_pkg::CH_GT) &&
                   char_in == cur_state.hchar) begin
                  extend_en = 1'b1;
                  ext_mode  = ctl_pkg::MODE_OPSH;
               end else if (ctl_pkg::two_char_op(cur_state.hchar, char_in)) begin
                  extend_en = 1'b1;
                  ext_mode  = ctl_pkg::MODE_OPDONE;
               end else begin
                  finish_en = 1'b1;
               end
            end
            ctl_pkg::MODE_OPSH: begin
               if (char_in == ctl_pkg::CH_EQ) begin
                  extend_en = 1'b1;
                  ext_mode  = ctl_pkg::MODE_OPDONE;
               end else begin
                  finish_en = 1'b1;
               end
            end
            ctl_pkg::MODE_OPDONE: begin
               finish_en = 1'b1;
            end
            default: begin
               nxt_state = ctl_pkg::start_token(cur_state, char_in);
            end
         endcase

         if (extend_en) begin
            emit             = 1'b1;
            nxt_state.hchar  = char_in;
            nxt_state.hfirst = 1'b0;
            nxt_state.mode   = ext_mode;
         end
         if (finish_en) begin
            emit        = 1'b1;
            result.last = 1'b1;
            nxt_state   = ctl_pkg::start_token(cur_state, char_in);
         end
      end
   end

endmodule

[rtl/ctl_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ctl_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic [7:0] req_tdata,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic [3:0] rsp_tuser
);

   logic empty_word;
   logic empty_ok;
   logic out_free;

   assign empty_word = rsp_tvalid && rsp_tuser[3];
   assign empty_ok   = rsp_tuser[2] && rsp_tlast && rsp_tuser[1:0] == ctl_pkg::KIND_STR &&
                       rsp_tdata == ctl_pkg::CH_NUL;
   assign out_free   = !rsp_tvalid || rsp_tready;

   // an empty-string word is a whole string token by itself, with a zero character
   `ASSERT_IMPLY(a_empty_whole, clock, reset, empty_word, empty_ok)

   // a stalled output word holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable({rsp_tdata, rsp_tlast, rsp_tuser}))

   // no word right after reset
   `ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_tvalid)

   // input is only blocked by a word waiting on a stalled receiver
   `ASSERT_IMPLY(a_ready_free, clock, reset, out_free, req_tready)

   // an offered input word stays put until it is taken
   `ASSERT_NEXT(a_req_hold, clock, reset, req_tvalid && !req_tready, req_tvalid && $stable(req_tdata))

endmodule

bind c_token_lexer ctl_checker u_ctl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

[sim/c_token_lexer_checker.sv]
`timescale 1ns / 1ps
module c_token_lexer_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,
   input  logic       rsp_tlast,
   input  logic [3:0] rsp_tuser,
   output int         fail_count,
   output int         pending
);

   typedef enum logic [3:0] {
      LX_IDLE, LX_NAME, LX_ZERO, LX_DEC, LX_HEX, LX_DQ, LX_SQ, LX_OP1, LX_SHIFT, LX_OPDONE
   } lex_mode_type;

   lex_mode_type lx_mode;
   logic [7:0]   lx_char;
   logic         lx_held;
   logic         lx_first;
   logic [1:0]   lx_kind;

   ctl_pkg::token_type due_tokens [$];

   function automatic bit is_num(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit word_start(input logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
             c == ctl_pkg::CH_UNDER || c == ctl_pkg::CH_DOLL;
   endfunction

   function automatic bit word_char(input logic [7:0] c);
      return word_start(c) || is_num(c);
   endfunction

   function automatic bit hex_char(input logic [7:0] c);
      return is_num(c) || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
   endfunction

   function automatic bit op_pair(input logic [7:0] c0, input logic [7:0] c1);
      case (c0)
         ctl_pkg::CH_LT, ctl_pkg::CH_GT, ctl_pkg::CH_EQ, ctl_pkg::CH_BANG,
         ctl_pkg::CH_STAR, ctl_pkg::CH_PCT, ctl_pkg::CH_CARET:
            return c1 == ctl_pkg::CH_EQ;
         ctl_pkg::CH_PLUS:
            return c1 == ctl_pkg::CH_EQ || c1 == ctl_pkg::CH_PLUS;
         ctl_pkg::CH_MINUS:
            return c1 == ctl_pkg::CH_EQ || c1 == ctl_pkg::CH_MINUS || c1 == ctl_pkg::CH_GT;
         ctl_pkg::CH_AMP:
            return c1 == ctl_pkg::CH_EQ || c1 == ctl_pkg::CH_AMP;
         ctl_pkg::CH_BAR:
            return c1 == ctl_pkg::CH_EQ || c1 == ctl_pkg::CH_BAR;
         default:
            return 1'b0;
      endcase
   endfunction

   function automatic ctl_pkg::token_type make_tok(input logic [7:0] ch,
                                                   input logic [1:0] kind,
                                                   input logic first, input logic last,
                                                   input logic empty);
      ctl_pkg::token_type t;
      t.ch    = ch;
      t.kind  = kind;
      t.first = first;
      t.last  = last;
      t.empty = empty;
      return t;
   endfunction

   task lex_clear();
      lx_mode  = LX_IDLE;
      lx_char  = 8'h00;
      lx_held  = 1'b0;
      lx_first = 1'b0;
      lx_kind  = ctl_pkg::KIND_NAME;
   endtask

   task take(input logic [7:0] c, input logic [1:0] kind, input lex_mode_type m);
      lx_char  = c;
      lx_held  = 1'b1;
      lx_first = 1'b1;
      lx_kind  = kind;
      lx_mode  = m;
   endtask

   // a byte opens a new token, or, if it is not part of any token, leaves the lexer idle
   task open_token(input logic [7:0] c);
      lx_held  = 1'b0;
      lx_first = 1'b0;
      if (c <= ctl_pkg::CH_SPACE || c[7]) begin
         lx_mode = LX_IDLE;
      end else if (word_start(c)) begin
         take(c, ctl_pkg::KIND_NAME, LX_NAME);
      end else if (is_num(c)) begin
         take(c, ctl_pkg::KIND_NUM, (c == "0") ? LX_ZERO : LX_DEC);
      end else if (c == ctl_pkg::CH_DQ) begin
         lx_mode = LX_DQ;
         lx_kind = ctl_pkg::KIND_STR;
      end else if (c == ctl_pkg::CH_SQ) begin
         lx_mode = LX_SQ;
         lx_kind = ctl_pkg::KIND_STR;
      end else if (c <= ctl_pkg::CH_TILDE) begin
         take(c, ctl_pkg::KIND_OP, LX_OP1);
      end else begin
         take(c, ctl_pkg::KIND_OP, LX_OPDONE);
      end
   endtask

   task grow(input logic [7:0] c, input lex_mode_type m, output ctl_pkg::token_type tk);
      tk       = make_tok(lx_char, lx_kind, lx_first, 1'b0, 1'b0);
      lx_char  = c;
      lx_first = 1'b0;
      lx_mode  = m;
   endtask

   task close_tok(input logic [7:0] c, output ctl_pkg::token_type tk);
      tk = make_tok(lx_char, lx_kind, lx_first, 1'b1, 1'b0);
      open_token(c);
   endtask

   task lex_step(input logic [7:0] c, output bit got, output ctl_pkg::token_type tk);
      lex_mode_type m;
      m   = lx_mode;
      got = 1'b1;
      tk  = '0;
      if (c == ctl_pkg::CH_NUL) begin
         if (lx_held)
            tk = make_tok(lx_char, lx_kind, lx_first, 1'b1, 1'b0);
         else if (m == LX_DQ || m == LX_SQ)
            tk = make_tok(ctl_pkg::CH_NUL, ctl_pkg::KIND_STR, 1'b1, 1'b1, 1'b1);
         else
            got = 1'b0;
         lex_clear();
      end else begin
         case (m)
            LX_NAME:
               if (word_char(c)) grow(c, LX_NAME, tk);
               else close_tok(c, tk);
            LX_ZERO:
               if (c == ctl_pkg::CH_LX || c == ctl_pkg::CH_UX) begin
                  grow(c, LX_HEX, tk);
               end else if (is_num(c)) begin
                  grow(c, LX_DEC, tk);
               end else if (c == ctl_pkg::CH_UNDER) begin
                  // underscore after a leading zero drops the hex option
                  lx_mode = LX_DEC;
                  got     = 1'b0;
               end else begin
                  close_tok(c, tk);
               end
            LX_DEC:
               if (is_num(c)) grow(c, LX_DEC, tk);
               else if (c == ctl_pkg::CH_UNDER) got = 1'b0;
               else close_tok(c, tk);
            LX_HEX:
               if (hex_char(c)) grow(c, LX_HEX, tk);
               else if (c == ctl_pkg::CH_UNDER) got = 1'b0;
               else close_tok(c, tk);
            LX_DQ, LX_SQ:
               if (c == ((m == LX_DQ) ? ctl_pkg::CH_DQ : ctl_pkg::CH_SQ)) begin
                  if (lx_held)
                     tk = make_tok(lx_char, ctl_pkg::KIND_STR, lx_first, 1'b1, 1'b0);
                  else
                     tk = make_tok(ctl_pkg::CH_NUL, ctl_pkg::KIND_STR, 1'b1, 1'b1, 1'b1);
                  lex_clear();
               end else if (lx_held) begin
                  grow(c, m, tk);
               end else begin
                  take(c, ctl_pkg::KIND_STR, m);
                  got = 1'b0;
               end
            LX_OP1:
               if ((lx_char == ctl_pkg::CH_LT || lx_char == ctl_pkg::CH_GT) && c == lx_char)
                  grow(c, LX_SHIFT, tk);
               else if (op_pair(lx_char, c))
                  grow(c, LX_OPDONE, tk);
               else
                  close_tok(c, tk);
            LX_SHIFT:
               if (c == ctl_pkg::CH_EQ) grow(c, LX_OPDONE, tk);
               else close_tok(c, tk);
            LX_OPDONE:
               close_tok(c, tk);
            default: begin
               open_token(c);
               got = 1'b0;
            end
         endcase
      end
   endtask

   always @(posedge clock) begin : watch
      ctl_pkg::token_type want;
      ctl_pkg::token_type seen;
      bit                 got;
      bit                 bad;
      if (reset) begin
         lex_clear();
         due_tokens.delete();
         fail_count <= 0;
      end else begin
         // results first: a byte accepted now cannot answer in the same cycle
         if (rsp_tvalid && rsp_tready) begin
            seen = make_tok(rsp_tdata, rsp_tuser[1:0], rsp_tuser[2], rsp_tlast, rsp_tuser[3]);
            if (due_tokens.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t unexpected word: ch=%h kind=%0d first=%b last=%b empty=%b",
                           $time, seen.ch, seen.kind, seen.first, seen.last, seen.empty);
               fail_count <= fail_count + 1;
            end else begin
               want = due_tokens.pop_front();
               // the character is don't-care on an empty-string mark
               bad = want.kind != seen.kind || want.first != seen.first ||
                     want.last != seen.last || want.empty != seen.empty ||
                     (!want.empty && want.ch != seen.ch);
               if (bad) begin
                  if (fail_count < 10)
                     $display({"%0t bad word: expected ch=%h kind=%0d first=%b last=%b ",
                               "empty=%b, got ch=%h kind=%0d first=%b last=%b empty=%b"},
                              $time, want.ch, want.kind, want.first, want.last, want.empty,
                              seen.ch, seen.kind, seen.first, seen.last, seen.empty);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            lex_step(req_tdata, got, want);
            if (got)
               due_tokens.push_back(want);
         end
      end
      pending <= due_tokens.size();
   end

endmodule

[sim/tb_c_token_lexer.sv]
`timescale 1ns / 1ps
module tb_c_token_lexer;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;
   logic [3:0] rsp_tuser;

   int fail_count;
   int pending;
   int sent       = 0;
   bit calm       = 1'b0;
   bit stall_req  = 1'b0;
   bit mid_pause  = 1'b0;

   // leading zero with underscore, empty string, quoted text, shift-assigns,
   // bare hex prefix, byte 127, a high byte, unterminated strings
   logic [7:0] opening [25] = '{
      "0", ctl_pkg::CH_UNDER, ctl_pkg::CH_LX, ctl_pkg::CH_DQ, ctl_pkg::CH_DQ,
      ctl_pkg::CH_SQ, "a", "b", ctl_pkg::CH_SQ,
      ctl_pkg::CH_LT, ctl_pkg::CH_LT, ctl_pkg::CH_EQ, ctl_pkg::CH_GT, ctl_pkg::CH_GT,
      ctl_pkg::CH_EQ, ctl_pkg::CH_SPACE, "0", ctl_pkg::CH_UX,
      8'h7F, 8'hFF, ctl_pkg::CH_DQ, "q", ctl_pkg::CH_NUL, ctl_pkg::CH_DQ, ctl_pkg::CH_NUL};

   string op_list [20] = '{"<<=", ">>=", "<=", ">=", "==", "!=", "+=", "-=", "*=", "%=",
                           "&=", "|=", "^=", "--", "->", "++", "&&", "||", "<<", ">>"};

   c_token_lexer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   c_token_lexer_checker token_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic bit word_byte(input logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || (c >= "0" && c <= "9") ||
             c == ctl_pkg::CH_UNDER || c == ctl_pkg::CH_DOLL;
   endfunction

   function automatic logic [7:0] pick_word_start();
      int r;
      r = $urandom_range(53);
      if (r < 26) return 8'("A" + r);
      else if (r < 52) return 8'("a" + r - 26);
      else if (r == 52) return ctl_pkg::CH_UNDER;
      else return ctl_pkg::CH_DOLL;
   endfunction

   function automatic logic [7:0] pick_hex_or_sep();
      int r;
      r = $urandom_range(23);
      if (r < 10) return 8'("0" + r);
      else if (r < 16) return 8'("a" + r - 10);
      else if (r < 22) return 8'("A" + r - 16);
      else if (r == 22) return ctl_pkg::CH_UNDER;
      else return "g";
   endfunction

   task send_byte(input logic [7:0] c);
      @(negedge clock);
      while (!calm && $urandom_range(99) < 28) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = c;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
   endtask

   // stop offering words until every expected token word is back
   task wait_empty();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task send_name();
      send_byte(pick_word_start());
      repeat ($urandom_range(0, 6)) begin
         if ($urandom_range(5) == 0) send_byte(8'("0" + $urandom_range(9)));
         else send_byte(pick_word_start());
      end
   endtask

   task send_number();
      int r;
      r = $urandom_range(3);
      if (r == 0) begin
         send_byte("0");
         send_byte($urandom_range(1) ? ctl_pkg::CH_LX : ctl_pkg::CH_UX);
         repeat ($urandom_range(0, 5)) send_byte(pick_hex_or_sep());
      end else begin
         if (r == 1) send_byte("0");
         else send_byte(8'("0" + $urandom_range(1, 9)));
         repeat ($urandom_range(0, 5)) begin
            if ($urandom_range(4) == 0) send_byte(ctl_pkg::CH_UNDER);
            else send_byte(8'("0" + $urandom_range(9)));
         end
      end
   endtask

   task send_string();
      logic [7:0] q;
      logic [7:0] b;
      q = $urandom_range(1) ? ctl_pkg::CH_DQ : ctl_pkg::CH_SQ;
      send_byte(q);
      repeat ($urandom_range(0, 6)) begin
         b = 8'($urandom_range(1, 255));
         if (b == q) b = ctl_pkg::CH_SPACE;
         send_byte(b);
      end
      if ($urandom_range(9) != 0) send_byte(q);
   endtask

   task send_op();
      string      s;
      logic [7:0] b;
      if ($urandom_range(2) == 0) begin
         do b = 8'($urandom_range(33, 127));
         while (word_byte(b) || b == ctl_pkg::CH_DQ || b == ctl_pkg::CH_SQ);
         send_byte(b);
      end else begin
         s = op_list[$urandom_range(19)];
         for (int i = 0; i < s.len(); i++) send_byte(s[i]);
      end
   endtask

   task send_blank();
      case ($urandom_range(3))
         0: send_byte(ctl_pkg::CH_SPACE);
         1: send_byte(8'h09);
         2: send_byte(8'($urandom_range(1, 32)));
         default: send_byte(8'($urandom_range(128, 255)));
      endcase
   endtask

   task send_line();
      repeat ($urandom_range(0, 8)) begin
         case ($urandom_range(19))
            0, 1, 2, 3:    send_name();
            4, 5, 6, 7:    send_number();
            8, 9, 10:      send_string();
            11, 12, 13, 14: send_op();
            15, 16, 17:    send_blank();
            default:       send_byte(8'($urandom_range(1, 255)));
         endcase
      end
      send_byte(ctl_pkg::CH_NUL);
   endtask

   // receiver: random back-pressure plus one long hold-off per request
   initial begin
      forever begin
         @(negedge clock);
         if (stall_req) begin
            stall_req  = 1'b0;
            rsp_tready = 1'b0;
            repeat (80) @(negedge clock);
         end
         rsp_tready = calm || $urandom_range(99) >= 28;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      foreach (opening[i]) send_byte(opening[i]);
      wait_empty();
      stall_req = 1'b1;
      while (sent < 1075) begin
         calm = sent >= 400 && sent < 560;
         if (sent >= 700 && !mid_pause) begin
            mid_pause = 1'b1;
            wait_empty();
            stall_req = 1'b1;
         end
         send_line();
      end
      calm = 1'b0;
      wait_empty();
      if (fail_count == 0)
         $display("c_token_lexer: match");
      else
         $display("c_token_lexer: mismatch");
      $finish;
   end

   initial begin
      #(5_000_000);
      $display("c_token_lexer: mismatch");
      $finish;
   end

endmodule
